// File: sv/tiny_vm_instruction_execute_macros.svh
// assertion macros for the tiny vm instruction execute block
// used by the top level only; no other dependencies
`ifndef TINY_VM_INSTRUCTION_EXECUTE_MACROS_SVH
`define TINY_VM_INSTRUCTION_EXECUTE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TVIE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvie assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define TVIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvie assertion failed");

`endif

// File: sv/tvie_pkg.sv
// shared types, opcodes and helpers of the tiny vm instruction execute block
// no dependencies; used by tvie_serial_unit and the top level module
`default_nettype none

package tvie_pkg;

   // widths of the address fields in the result word
   localparam int PC_OUT_BITS  = 12;

   // register file geometry
   localparam int REG_COUNT    = 12;
   localparam int REG_IDX_BITS = 4;

   // opcodes
   localparam logic [7:0] FUNC_HALT     = 8'd0;
   localparam logic [7:0] FUNC_HALT_ALT = 8'd1;
   localparam logic [7:0] FUNC_GOTO     = 8'd2;
   localparam logic [7:0] FUNC_PRINT    = 8'd3;
   localparam logic [7:0] FUNC_CLEAR    = 8'd4;
   localparam logic [7:0] FUNC_COLOUR   = 8'd5;
   localparam logic [7:0] FUNC_SPRITE   = 8'd6;
   localparam logic [7:0] FUNC_ALU      = 8'd7;
   localparam logic [7:0] FUNC_SET_LIT  = 8'd8;
   localparam logic [7:0] FUNC_ADD_LIT  = 8'd9;
   localparam logic [7:0] FUNC_RANDOM   = 8'd10;
   localparam logic [7:0] FUNC_CMP_REG  = 8'd11;
   localparam logic [7:0] FUNC_EQ_LIT   = 8'd12;
   localparam logic [7:0] FUNC_NE_LIT   = 8'd13;
   localparam logic [7:0] FUNC_KEY      = 8'd14;

   // register-register operators
   localparam logic [7:0] ALU_SET = 8'd1;
   localparam logic [7:0] ALU_ADD = 8'd2;
   localparam logic [7:0] ALU_SUB = 8'd3;
   localparam logic [7:0] ALU_MUL = 8'd4;
   localparam logic [7:0] ALU_DIV = 8'd5;
   localparam logic [7:0] ALU_MOD = 8'd6;
   localparam logic [7:0] ALU_AND = 8'd7;
   localparam logic [7:0] ALU_OR  = 8'd8;
   localparam logic [7:0] ALU_XOR = 8'd9;

   // comparisons
   localparam logic [7:0] CMP_EQ = 8'd1;
   localparam logic [7:0] CMP_NE = 8'd2;
   localparam logic [7:0] CMP_LT = 8'd3;
   localparam logic [7:0] CMP_LE = 8'd4;
   localparam logic [7:0] CMP_GT = 8'd5;
   localparam logic [7:0] CMP_GE = 8'd6;

   // key ids
   localparam logic [7:0] KEY_FIRST = 8'd1;
   localparam logic [7:0] KEY_LAST  = 8'd5;

   // fixed register ids
   localparam logic [7:0] REG_X_ID      = 8'd1;
   localparam logic [7:0] REG_Y_ID      = 8'd2;
   localparam logic [7:0] REG_FRAME_ID  = 8'd11;
   localparam logic [7:0] REG_COLOUR_ID = 8'd12;

   // event kinds
   localparam logic [2:0] EVENT_NONE   = 3'd0;
   localparam logic [2:0] EVENT_PRINT  = 3'd1;
   localparam logic [2:0] EVENT_CLEAR  = 3'd2;
   localparam logic [2:0] EVENT_SPRITE = 3'd3;
   localparam logic [2:0] EVENT_HALT   = 3'd4;

   // full scale of the random fraction
   localparam logic [16:0] RANDOM_FULL_SCALE = 17'd65535;

   typedef struct packed {
      logic [7:0]  func;
      logic [7:0]  byte_a;
      logic [7:0]  byte_b;
      logic [7:0]  byte_c;
      logic [4:0]  keys_down;
      logic [15:0] random_fraction;
   } req_type;

   typedef struct packed {
      logic [PC_OUT_BITS-1:0] next_pc;
      logic [2:0]             event_kind;
      logic [7:0]             print_value;
      logic [2:0]             clear_color;
      logic [PC_OUT_BITS-1:0] sprite_address;
      logic [7:0]             sprite_x;
      logic [7:0]             sprite_y;
      logic [2:0]             sprite_color;
   } rsp_type;

   // command to the bit-serial multiply / divide unit
   typedef struct packed {
      logic        start;
      logic [15:0] multiplicand;
      logic [7:0]  operand;
      logic [8:0]  divisor;
   } serial_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } serial_status_type;

   function automatic logic reg_in_range(input logic [7:0] id);
      return (id >= 8'd1) && (id <= 8'(REG_COUNT));
   endfunction

   function automatic logic [REG_IDX_BITS-1:0] reg_index(input logic [7:0] id);
      logic [7:0] off;
      off = id - 8'd1;
      return reg_in_range(id) ? off[REG_IDX_BITS-1:0] : '0;
   endfunction

endpackage

`default_nettype wire

// File: sv/tvie_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module tvie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 12
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_0,
   output logic      [WIDTH-1:0]         rd_data_0,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_1,
   output logic      [WIDTH-1:0]         rd_data_1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_0_ff;
   logic [WIDTH-1:0] rd_data_1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_0_ff <= mem_ff[rd_addr_0];
      rd_data_1_ff <= mem_ff[rd_addr_1];
   end

   assign rd_data_0 = rd_data_0_ff;
   assign rd_data_1 = rd_data_1_ff;

endmodule

`default_nettype wire

// File: sv/tvie_serial_unit.sv
// bit-serial shift-add multiplier and restoring divider, one bit per cycle
// depends on tvie_pkg for the command and status structs
`default_nettype none

module tvie_serial_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tvie_pkg::serial_cmd_type     cmd,
   output tvie_pkg::serial_status_type       status,
   output logic                      [23:0]  product,
   output logic                      [7:0]   quotient,
   output logic                      [7:0]   remainder
);

   localparam int STEPS      = 8;
   localparam int COUNT_BITS = $clog2(STEPS);
   localparam logic [COUNT_BITS-1:0] STEP_LAST = COUNT_BITS'(STEPS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [23:0]           acc_ff, acc_in;
   logic [23:0]           mcand_ff, mcand_in;
   logic [7:0]            mplier_ff, mplier_in;
   logic [7:0]            quo_ff, quo_in;
   logic [7:0]            rem_ff, rem_in;
   logic [8:0]            divisor_ff, divisor_in;
   logic [8:0]            trial;
   logic [8:0]            diff;
   logic                  take;

   // both the multiply and the divide step every cycle while busy; the caller picks its result
   always_comb begin
      busy_in    = busy_ff;
      done_in    = done_ff;
      count_in   = count_ff;
      acc_in     = acc_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, quo_ff[7]};
      take       = trial >= divisor_ff;
      diff       = trial - divisor_ff;
      if (cmd.start) begin
         busy_in    = 1'b1;
         done_in    = 1'b0;
         count_in   = '0;
         acc_in     = '0;
         mcand_in   = {8'h00, cmd.multiplicand};
         mplier_in  = cmd.operand;
         quo_in     = cmd.operand;
         rem_in     = '0;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[22:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[7:1]};
         // zero divisor always takes: quotient all ones, remainder the dividend
         rem_in    = take ? diff[7:0] : trial[7:0];
         quo_in    = {quo_ff[6:0], take};
         count_in  = count_ff + COUNT_BITS'(1);
         if (count_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

// File: sv/tiny_vm_instruction_execute.sv
// tiny vm instruction execute: one instruction word in, one result word out
// uses tvie_pkg, tvie_ram, tvie_serial_unit and the assertion macro header
// one word at a time: mul, div, mod, random, clear and sprite take longer, as they
// wait on the 8-step bit-serial multiply / divide unit
// result sits in an output register so the next word is taken while it waits
// synchronous active-high reset clears pc, state, register and result valid bits
`default_nettype none

`include "tiny_vm_instruction_execute_macros.svh"

module tiny_vm_instruction_execute #(
   parameter int ADDRESS_BITS    = 12,
   parameter int PALETTE_ENTRIES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tvie_pkg::req_type req_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output tvie_pkg::rsp_type      rsp_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall
);

   localparam int OUT_ADDR_BITS = tvie_pkg::PC_OUT_BITS;
   localparam int IDX_BITS      = tvie_pkg::REG_IDX_BITS;
   // divisor for palette reduction, wide enough for 256 entries
   localparam logic [8:0] PALETTE_DIV = 9'(PALETTE_ENTRIES);

   // sequencer: read two registers, read colour, optional serial op, retire
   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_LATCH,
      S_COL,
      S_WAIT,
      S_DONE
   } state_type;

   state_type                       state_ff, state_in;
   tvie_pkg::req_type               req_ff, req_in;
   logic [ADDRESS_BITS-1:0]         pc_ff, pc_in;
   logic [tvie_pkg::REG_COUNT-1:0]  valid_ff, valid_in;
   tvie_pkg::rsp_type               rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      d_ff, d_in;
   logic [7:0]                      s_ff, s_in;
   logic                            ok0_ff, ok0_in;
   logic                            ok1_ff, ok1_in;

   // register file read / write
   logic [7:0]          rd_id0, rd_id1;
   logic [IDX_BITS-1:0] rd_idx0, rd_idx1;
   logic [7:0]          rd_data0, rd_data1;
   logic                ram_wr_en;
   logic [IDX_BITS-1:0] ram_wr_addr;

   // serial unit
   tvie_pkg::serial_cmd_type    serial_cmd;
   tvie_pkg::serial_status_type serial_status;
   logic [23:0]                 product;
   logic [7:0]                  quotient;
   logic [7:0]                  remainder;

   // execute
   logic [11:0]             nn_sum;
   logic [7:0]              nn;
   logic [16:0]             nnn_sum;
   logic [ADDRESS_BITS-1:0] nnn;
   logic [ADDRESS_BITS-1:0] pc_plus4;
   logic [ADDRESS_BITS-1:0] next_pc;
   logic [16:0]             rnd_sum;
   logic [7:0]              rnd_q;
   logic [7:0]              colour;
   logic [7:0]              key_off;
   logic                    needs_serial;
   logic                    pass;
   logic                    wr_flag;
   logic [7:0]              wr_id;
   logic [7:0]              wr_data;
   logic                    finish;
   tvie_pkg::rsp_type       rsp_next;

   // literals: nn = b*0x10 + c mod 256, nnn = a*0x100 + b*0x10 + c mod address space
   always_comb begin
      nn_sum   = {req_ff.byte_b, 4'h0} + {4'h0, req_ff.byte_c};
      nn       = nn_sum[7:0];
      nnn_sum  = {1'b0, req_ff.byte_a, 8'h00} + {5'h00, req_ff.byte_b, 4'h0}
               + {9'h000, req_ff.byte_c};
      nnn      = nnn_sum[ADDRESS_BITS-1:0];
      pc_plus4 = pc_ff + ADDRESS_BITS'(4);
   end

   // floor(p / 65535) with p < 65535 * 256: high half plus one correction step
   always_comb begin
      rnd_sum = {1'b0, product[15:0]} + {9'h000, product[23:16]};
      rnd_q   = product[23:16] + {7'h00, rnd_sum >= tvie_pkg::RANDOM_FULL_SCALE};
   end

   // read addresses: port 0 takes the colour register in the latch cycle
   always_comb begin
      rd_id0 = req_ff.byte_a;
      rd_id1 = req_ff.byte_c;
      if (state_ff == S_LATCH) begin
         rd_id0 = tvie_pkg::REG_COLOUR_ID;
      end else begin
         case (req_ff.func)
            tvie_pkg::FUNC_HALT, tvie_pkg::FUNC_HALT_ALT: begin
               rd_id0 = tvie_pkg::REG_FRAME_ID;
            end
            tvie_pkg::FUNC_SPRITE: begin
               rd_id0 = tvie_pkg::REG_X_ID;
               rd_id1 = tvie_pkg::REG_Y_ID;
            end
            tvie_pkg::FUNC_ALU, tvie_pkg::FUNC_CMP_REG: begin
               rd_id0 = req_ff.byte_b;
               rd_id1 = req_ff.byte_c;
            end
            default: begin
            end
         endcase
      end
      rd_idx0 = tvie_pkg::reg_index(rd_id0);
      rd_idx1 = tvie_pkg::reg_index(rd_id1);
      // bad ids and never-written entries read as zero
      ok0_in  = tvie_pkg::reg_in_range(rd_id0) && valid_ff[rd_idx0];
      ok1_in  = tvie_pkg::reg_in_range(rd_id1) && valid_ff[rd_idx1];
   end

   assign colour = ok0_ff ? rd_data0 : 8'h00;

   // serial unit operands
   always_comb begin
      needs_serial = ((req_ff.func == tvie_pkg::FUNC_ALU)
                      && (req_ff.byte_a inside {tvie_pkg::ALU_MUL, tvie_pkg::ALU_DIV,
                                                tvie_pkg::ALU_MOD}))
                   || (req_ff.func inside {tvie_pkg::FUNC_CLEAR, tvie_pkg::FUNC_SPRITE,
                                           tvie_pkg::FUNC_RANDOM});
      serial_cmd.start        = (state_ff == S_COL) && needs_serial;
      serial_cmd.multiplicand = {8'h00, s_ff};
      serial_cmd.operand      = d_ff;
      serial_cmd.divisor      = {1'b0, s_ff};
      case (req_ff.func)
         tvie_pkg::FUNC_CLEAR: begin
            serial_cmd.operand = req_ff.byte_a;
            serial_cmd.divisor = PALETTE_DIV;
         end
         tvie_pkg::FUNC_SPRITE: begin
            serial_cmd.operand = colour;
            serial_cmd.divisor = PALETTE_DIV;
         end
         tvie_pkg::FUNC_RANDOM: begin
            serial_cmd.multiplicand = req_ff.random_fraction;
            serial_cmd.operand      = nn;
         end
         default: begin
         end
      endcase
   end

   // retire: next pc, register write-back and the result word
   always_comb begin
      pass     = 1'b1;
      wr_flag  = 1'b0;
      wr_id    = req_ff.byte_a;
      wr_data  = d_ff;
      next_pc  = pc_plus4;
      key_off  = req_ff.byte_a - tvie_pkg::KEY_FIRST;
      rsp_next = '0;
      case (req_ff.func)
         tvie_pkg::FUNC_HALT, tvie_pkg::FUNC_HALT_ALT: begin
            // frame register ticks and execution restarts at address zero
            next_pc             = '0;
            wr_flag             = 1'b1;
            wr_id               = tvie_pkg::REG_FRAME_ID;
            wr_data             = d_ff + 8'd1;
            rsp_next.event_kind = tvie_pkg::EVENT_HALT;
         end
         tvie_pkg::FUNC_GOTO: begin
            next_pc = nnn;
         end
         tvie_pkg::FUNC_PRINT: begin
            rsp_next.event_kind  = tvie_pkg::EVENT_PRINT;
            rsp_next.print_value = d_ff;
         end
         tvie_pkg::FUNC_CLEAR: begin
            rsp_next.event_kind  = tvie_pkg::EVENT_CLEAR;
            rsp_next.clear_color = remainder[2:0];
         end
         tvie_pkg::FUNC_COLOUR: begin
            wr_flag = 1'b1;
            wr_id   = tvie_pkg::REG_COLOUR_ID;
            wr_data = req_ff.byte_a;
         end
         tvie_pkg::FUNC_SPRITE: begin
            rsp_next.event_kind     = tvie_pkg::EVENT_SPRITE;
            rsp_next.sprite_address = OUT_ADDR_BITS'(nnn);
            rsp_next.sprite_x       = d_ff;
            rsp_next.sprite_y       = s_ff;
            rsp_next.sprite_color   = remainder[2:0];
         end
         tvie_pkg::FUNC_ALU: begin
            wr_flag = 1'b1;
            wr_id   = req_ff.byte_b;
            case (req_ff.byte_a)
               tvie_pkg::ALU_SET: wr_data = s_ff;
               tvie_pkg::ALU_ADD: wr_data = d_ff + s_ff;
               tvie_pkg::ALU_SUB: wr_data = d_ff - s_ff;
               tvie_pkg::ALU_MUL: wr_data = product[7:0];
               tvie_pkg::ALU_DIV: wr_data = quotient;
               tvie_pkg::ALU_MOD: wr_data = remainder;
               tvie_pkg::ALU_AND: wr_data = d_ff & s_ff;
               tvie_pkg::ALU_OR:  wr_data = d_ff | s_ff;
               tvie_pkg::ALU_XOR: wr_data = d_ff ^ s_ff;
               default:           wr_flag = 1'b0;
            endcase
         end
         tvie_pkg::FUNC_SET_LIT: begin
            wr_flag = 1'b1;
            wr_data = nn;
         end
         tvie_pkg::FUNC_ADD_LIT: begin
            wr_flag = 1'b1;
            wr_data = d_ff + nn;
         end
         tvie_pkg::FUNC_RANDOM: begin
            wr_flag = 1'b1;
            wr_data = rnd_q;
         end
         tvie_pkg::FUNC_CMP_REG: begin
            case (req_ff.byte_a)
               tvie_pkg::CMP_EQ: pass = d_ff == s_ff;
               tvie_pkg::CMP_NE: pass = d_ff != s_ff;
               tvie_pkg::CMP_LT: pass = d_ff <  s_ff;
               tvie_pkg::CMP_LE: pass = d_ff <= s_ff;
               tvie_pkg::CMP_GT: pass = d_ff >  s_ff;
               tvie_pkg::CMP_GE: pass = d_ff >= s_ff;
               default:          pass = 1'b1;
            endcase
         end
         tvie_pkg::FUNC_EQ_LIT: begin
            pass = d_ff == nn;
         end
         tvie_pkg::FUNC_NE_LIT: begin
            pass = d_ff != nn;
         end
         tvie_pkg::FUNC_KEY: begin
            // unknown key ids count as pressed
            if ((req_ff.byte_a >= tvie_pkg::KEY_FIRST) &&
                (req_ff.byte_a <= tvie_pkg::KEY_LAST)) begin
               pass = req_ff.keys_down[key_off[2:0]];
            end
         end
         default: begin
         end
      endcase
      // failed test skips the following instruction
      if (!pass) begin
         next_pc = pc_plus4 + ADDRESS_BITS'(4);
      end
      rsp_next.next_pc = OUT_ADDR_BITS'(next_pc);
   end

   // retire only when the output register is free or being emptied
   assign finish      = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign ram_wr_en   = finish && wr_flag && tvie_pkg::reg_in_range(wr_id);
   assign ram_wr_addr = tvie_pkg::reg_index(wr_id);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pc_in        = pc_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      d_in         = d_ff;
      s_in         = s_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_LATCH;
         end
         S_LATCH: begin
            d_in     = ok0_ff ? rd_data0 : 8'h00;
            s_in     = ok1_ff ? rd_data1 : 8'h00;
            state_in = S_COL;
         end
         S_COL: begin
            state_in = needs_serial ? S_WAIT : S_DONE;
         end
         S_WAIT: begin
            if (serial_status.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (finish) begin
               pc_in        = next_pc;
               rsp_in       = rsp_next;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (ram_wr_en) begin
                  valid_in[ram_wr_addr] = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      d_ff   <= d_in;
      s_ff   <= s_in;
      ok0_ff <= ok0_in;
      ok1_ff <= ok1_in;
   end

   tvie_ram #(
      .WIDTH (8),
      .DEPTH (tvie_pkg::REG_COUNT)
   ) u_regs (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (wr_data),
      .rd_addr_0 (rd_idx0),
      .rd_data_0 (rd_data0),
      .rd_addr_1 (rd_idx1),
      .rd_data_1 (rd_data1)
   );

   tvie_serial_unit u_serial (
      .clock     (clock),
      .reset     (reset),
      .cmd       (serial_cmd),
      .status    (serial_status),
      .product   (product),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // an accepted word holds off the next one until it retires
   `TVIE_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && !req_stall, req_stall)
   // waiting state always has a serial op in flight or finished
   `TVIE_ASSERT_IMP(a_wait_serial, clock, reset, state_ff == S_WAIT, serial_status.busy || serial_status.done)
   // register file is written only when a word retires
   `TVIE_ASSERT_IMP(a_write_at_retire, clock, reset, ram_wr_en, state_ff == S_DONE)
   // a retire into an empty output register always shows a result
   `TVIE_ASSERT_NEXT(a_retire_shows, clock, reset, state_ff == S_DONE && !rsp_valid_ff, rsp_valid_ff)

endmodule

`default_nettype wire

// File: tb/sv/tb_tiny_vm_instruction_execute.sv
// testbench for tiny_vm_instruction_execute: directed and random instruction words
// checked against a cycle-free model of the register file and program counter
// depends on tvie_pkg and the block itself
`timescale 1ns / 100ps

module tb_tiny_vm_instruction_execute;
   import tvie_pkg::*;

   // block configuration as instantiated below (defaults)
   localparam int ADDR_BITS = 12;
   localparam int PALETTE   = 8;

   // run shape
   localparam int RANDOM_WORDS = 600;
   localparam int CALM_FIRST   = 300;   // random words sent with no sender gaps
   localparam int CALM_LAST    = 420;
   localparam int HOLD_START   = 1200;  // receiver cycle where the long hold-off starts
   localparam int HOLD_CYCLES  = 200;
   localparam int CALM_START   = 3000;  // receiver cycles with no stalls at all
   localparam int CALM_END     = 4200;
   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG     = 2000;
   localparam int MAX_REPORTS  = 10;

   // scoreboard: own copy of the vm state, predicts one result word per instruction
   class instr_scoreboard;
      logic [7:0]           regs [1:REG_COUNT];
      logic [ADDR_BITS-1:0] pc;
      rsp_type              expected_q [$];
      int                   failures;

      function new();
         foreach (regs[i]) regs[i] = 8'h00;
         pc       = '0;
         failures = 0;
      endfunction

      // ids outside 1..12 read as zero
      function logic [7:0] read_reg(input logic [7:0] id);
         if (id >= 8'd1 && id <= 8'(REG_COUNT)) return regs[id];
         return 8'h00;
      endfunction

      // writes to ids outside 1..12 are dropped
      function void write_reg(input logic [7:0] id, input logic [7:0] v);
         if (id >= 8'd1 && id <= 8'(REG_COUNT)) regs[id] = v;
      endfunction

      // unknown comparison kinds count as true
      function bit compare_regs(input logic [7:0] kind, input logic [7:0] x,
                                input logic [7:0] y);
         case (kind)
            CMP_EQ: return x == y;
            CMP_NE: return x != y;
            CMP_LT: return x < y;
            CMP_LE: return x <= y;
            CMP_GT: return x > y;
            CMP_GE: return x >= y;
            default: return 1'b1;
         endcase
      endfunction

      // execute one accepted instruction word and queue its result word
      function void note_request(input req_type r);
         rsp_type              res;
         logic [7:0]           nn, d, s, v;
         logic [15:0]          addr_sum;
         logic [ADDR_BITS-1:0] nnn, nxt;
         int unsigned          scaled;
         bit                   taken, wr;
         res      = '0;
         taken    = 1'b1;
         wr       = 1'b1;
         v        = 8'h00;
         nn       = {r.byte_b[3:0], 4'h0} + r.byte_c;
         addr_sum = {r.byte_a, 8'h00} + {4'h0, r.byte_b, 4'h0} + {8'h00, r.byte_c};
         nnn      = addr_sum[ADDR_BITS-1:0];
         nxt      = pc + ADDR_BITS'(4);
         case (r.func)
            FUNC_HALT, FUNC_HALT_ALT: begin
               nxt = '0;
               write_reg(REG_FRAME_ID, read_reg(REG_FRAME_ID) + 8'd1);
               res.event_kind = EVENT_HALT;
            end
            FUNC_GOTO: nxt = nnn;
            FUNC_PRINT: begin
               res.event_kind  = EVENT_PRINT;
               res.print_value = read_reg(r.byte_a);
            end
            FUNC_CLEAR: begin
               res.event_kind  = EVENT_CLEAR;
               res.clear_color = 3'(r.byte_a % PALETTE);
            end
            FUNC_COLOUR: write_reg(REG_COLOUR_ID, r.byte_a);
            FUNC_SPRITE: begin
               res.event_kind     = EVENT_SPRITE;
               res.sprite_address = nnn;
               res.sprite_x       = read_reg(REG_X_ID);
               res.sprite_y       = read_reg(REG_Y_ID);
               res.sprite_color   = 3'(read_reg(REG_COLOUR_ID) % PALETTE);
            end
            FUNC_ALU: begin
               d = read_reg(r.byte_b);
               s = read_reg(r.byte_c);
               case (r.byte_a)
                  ALU_SET: v = s;
                  ALU_ADD: v = d + s;
                  ALU_SUB: v = d - s;
                  ALU_MUL: v = d * s;
                  ALU_DIV: v = (s != 8'h00) ? d / s : 8'hff;
                  ALU_MOD: v = (s != 8'h00) ? d % s : d;
                  ALU_AND: v = d & s;
                  ALU_OR:  v = d | s;
                  ALU_XOR: v = d ^ s;
                  default: wr = 1'b0;
               endcase
               if (wr) write_reg(r.byte_b, v);
            end
            FUNC_SET_LIT: write_reg(r.byte_a, nn);
            FUNC_ADD_LIT: write_reg(r.byte_a, read_reg(r.byte_a) + nn);
            FUNC_RANDOM: begin
               scaled = (32'(r.random_fraction) * 32'(nn)) / 32'(RANDOM_FULL_SCALE);
               write_reg(r.byte_a, 8'(scaled));
            end
            FUNC_CMP_REG: taken = compare_regs(r.byte_a, read_reg(r.byte_b),
                                               read_reg(r.byte_c));
            FUNC_EQ_LIT: taken = read_reg(r.byte_a) == nn;
            FUNC_NE_LIT: taken = read_reg(r.byte_a) != nn;
            FUNC_KEY: begin
               if (r.byte_a >= KEY_FIRST && r.byte_a <= KEY_LAST)
                  taken = r.keys_down[r.byte_a - KEY_FIRST];
            end
            default: ;
         endcase
         // failed test skips the next instruction
         if (!taken) nxt = nxt + ADDR_BITS'(4);
         pc          = nxt;
         res.next_pc = nxt;
         expected_q.push_back(res);
      endfunction

      // compare an accepted result word with the oldest prediction
      function void check_response(input rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected result word: pc=%h event=%0d", got.next_pc,
                        got.event_kind);
            return;
         end
         want = expected_q.pop_front();
         if (got.next_pc !== want.next_pc || got.event_kind !== want.event_kind ||
             got.print_value !== want.print_value ||
             got.clear_color !== want.clear_color ||
             got.sprite_address !== want.sprite_address ||
             got.sprite_x !== want.sprite_x || got.sprite_y !== want.sprite_y ||
             got.sprite_color !== want.sprite_color) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("mismatch expected: pc=%h ev=%0d pv=%h cc=%0d sa=%h sx=%h sy=%h sc=%0d",
                        want.next_pc, want.event_kind, want.print_value, want.clear_color,
                        want.sprite_address, want.sprite_x, want.sprite_y,
                        want.sprite_color);
               $display("         actual:   pc=%h ev=%0d pv=%h cc=%0d sa=%h sx=%h sy=%h sc=%0d",
                        got.next_pc, got.event_kind, got.print_value, got.clear_color,
                        got.sprite_address, got.sprite_x, got.sprite_y,
                        got.sprite_color);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // every input has a known value from time zero
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   req_type req_data  = '0;
   logic    req_valid = 1'b0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   rsp_type rsp_data;
   logic    rsp_valid;

   instr_scoreboard sb = new();

   tiny_vm_instruction_execute i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // pack one instruction word
   function automatic req_type make_word(input logic [7:0] f, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c,
                                         input logic [4:0] keys, input logic [15:0] frac);
      req_type w;
      w.func            = f;
      w.byte_a          = a;
      w.byte_b          = b;
      w.byte_c          = c;
      w.keys_down       = keys;
      w.random_fraction = frac;
      return w;
   endfunction

   // mostly a legal register id, now and then any byte
   function automatic logic [7:0] pick_reg();
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      return 8'($urandom_range(1, REG_COUNT));
   endfunction

   // mostly a known operator / comparison / key code, now and then any byte
   function automatic logic [7:0] pick_code(input int last);
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      return 8'($urandom_range(1, last));
   endfunction

   // random instruction: mostly well-formed, the rest pure noise
   function automatic req_type random_word();
      req_type w;
      w = make_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    5'($urandom), 16'($urandom));
      // hit the ends of the random scale now and then
      if ($urandom_range(0, 9) == 0)
         w.random_fraction = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      if ($urandom_range(0, 99) < 85) begin
         w.func = 8'($urandom_range(0, 14));
         case (w.func)
            FUNC_PRINT, FUNC_SET_LIT, FUNC_ADD_LIT, FUNC_RANDOM, FUNC_EQ_LIT,
            FUNC_NE_LIT: w.byte_a = pick_reg();
            FUNC_ALU: begin
               w.byte_a = pick_code(9);
               w.byte_b = pick_reg();
               w.byte_c = pick_reg();
            end
            FUNC_CMP_REG: begin
               w.byte_a = pick_code(6);
               w.byte_b = pick_reg();
               w.byte_c = pick_reg();
            end
            FUNC_KEY: w.byte_a = pick_code(5);
            default: ;
         endcase
      end
      return w;
   endfunction

   // offer one word and hold it until the block takes it; sometimes idle first
   task automatic send_word(input req_type w, input bit calm);
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // field extremes, every opcode and operator, and the special cases
   task automatic run_directed();
      send_word(make_word(FUNC_SET_LIT, 8'd1, 8'h0f, 8'h0f, 5'h00, 16'h0000), 1'b0);
      // literal built from full bytes wraps modulo 256
      send_word(make_word(FUNC_SET_LIT, 8'd4, 8'hff, 8'hff, 5'h1f, 16'hffff), 1'b0);
      // add literal wraps the register to zero
      send_word(make_word(FUNC_ADD_LIT, 8'd1, 8'h00, 8'h01, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_ALU, ALU_ADD, 8'd3, 8'd4, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_ALU, ALU_SUB, 8'd2, 8'd4, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_ALU, ALU_MUL, 8'd3, 8'd4, 5'h00, 16'h0000), 1'b0);
      // divide and modulo by zero
      send_word(make_word(FUNC_ALU, ALU_DIV, 8'd3, 8'd5, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_ALU, ALU_MOD, 8'd4, 8'd5, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_ALU, ALU_DIV, 8'd4, 8'd2, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_ALU, ALU_MOD, 8'd3, 8'd2, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_ALU, ALU_AND, 8'd3, 8'd4, 5'h00, 16'h0000), 1'b0);
      // source id out of range reads as zero
      send_word(make_word(FUNC_ALU, ALU_OR, 8'd2, 8'hff, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_ALU, ALU_XOR, 8'd4, 8'd3, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_ALU, ALU_SET, 8'd5, 8'd4, 5'h00, 16'h0000), 1'b0);
      // unknown operator leaves the registers alone
      send_word(make_word(FUNC_ALU, 8'hff, 8'd4, 8'd4, 5'h00, 16'h0000), 1'b0);
      // destination id out of range is not written
      send_word(make_word(FUNC_SET_LIT, 8'd0, 8'h01, 8'h02, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_RANDOM, 8'd6, 8'h0f, 8'h0f, 5'h00, 16'hffff), 1'b0);
      send_word(make_word(FUNC_RANDOM, 8'd7, 8'h0f, 8'h0f, 5'h00, 16'h0000), 1'b0);
      // colour keeps the whole byte, sprite takes it modulo the palette
      send_word(make_word(FUNC_COLOUR, 8'hff, 8'h00, 8'h00, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_SPRITE, 8'hff, 8'hff, 8'hff, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_CLEAR, 8'hff, 8'h00, 8'h00, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_PRINT, 8'd4, 8'h00, 8'h00, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_CMP_REG, CMP_GT, 8'd4, 8'd6, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_EQ_LIT, 8'd1, 8'h00, 8'h00, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_NE_LIT, 8'd1, 8'h00, 8'h00, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_KEY, KEY_LAST, 8'h00, 8'h00, 5'h0f, 16'h0000), 1'b0);
      // unknown key id never skips
      send_word(make_word(FUNC_KEY, 8'd0, 8'h00, 8'h00, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_GOTO, 8'hff, 8'hff, 8'hff, 5'h00, 16'h0000), 1'b0);
      // unknown opcode is a no-op
      send_word(make_word(8'hff, 8'hff, 8'hff, 8'hff, 5'h1f, 16'hffff), 1'b0);
      send_word(make_word(FUNC_HALT, 8'h00, 8'h00, 8'h00, 5'h00, 16'h0000), 1'b0);
      send_word(make_word(FUNC_HALT_ALT, 8'h00, 8'h00, 8'h00, 5'h00, 16'h0000), 1'b0);
   endtask

   // monitor: both handshakes sampled with pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
      end
   end

   // receiver: random stalls, one long hold-off to back up the block, one calm stretch
   initial begin
      int cycle;
      int hold;
      cycle = 0;
      hold  = 0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle == HOLD_START) hold = HOLD_CYCLES;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (cycle >= CALM_START && cycle < CALM_END) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 7);
         end
      end
   end

   // watchdog: too long with no word moving on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("status: fail");
      $finish;
   end

   // sender and end of run
   initial begin
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (n = 0; n < RANDOM_WORDS; n++)
         send_word(random_word(), n >= CALM_FIRST && n < CALM_LAST);
      req_valid <= 1'b0;
      // drain, then give any stray word time to show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/tvie_pkg.sv
sv/tvie_ram.sv
sv/tvie_serial_unit.sv
sv/tiny_vm_instruction_execute.sv
tb/sv/tb_tiny_vm_instruction_execute.sv
